/* rtl/core/tmc_pkg.sv */
// ----------------------------------------------------------------------------
// tmc_pkg
// Shared types and constants of the transform matrix composer: opcodes,
// controller state codes, controller/datapath command and status structs,
// CORDIC constants.
// ----------------------------------------------------------------------------
package tmc_pkg;

  localparam logic [2:0] OP_ROT_X  = 3'd0;
  localparam logic [2:0] OP_ROT_Y  = 3'd1;
  localparam logic [2:0] OP_ROT_Z  = 3'd2;
  localparam logic [2:0] OP_TRANS  = 3'd3;
  localparam logic [2:0] OP_IDENT  = 3'd4;

  localparam int CordicIters = 16;
  localparam int CordicFrac  = 30;
  localparam logic [33:0] CORDIC_X0 = 34'h026DD3B6A;

  localparam logic [31:0] ATAN_TURNS [CordicIters] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
  };

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_CORDIC = 6'b000010,
    ST_LOAD   = 6'b000100,
    ST_MAC    = 6'b001000,
    ST_DRAIN  = 6'b010000,
    ST_EMIT   = 6'b100000
  } state_e;

  typedef struct packed {
    logic       capture;
    logic       cordic_step;
    logic [3:0] iter;
    logic       rd_issue;
    logic [1:0] rd_row;
    logic       mac_issue;
    logic [1:0] mac_k;
    logic [1:0] row;
    logic       finish;
  } dp_cmd_t;

  typedef struct packed {
    logic item_ok;
    logic is_rot;
  } dp_sts_t;

endpackage

/* rtl/core/tmc_ram.sv */
// ----------------------------------------------------------------------------
// tmc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tmc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* rtl/core/tmc_ctrl.sv */
// ----------------------------------------------------------------------------
// tmc_ctrl
// Sequencer of the composer: CORDIC iterations, matrix row reads,
// multiply-accumulate steps and row emission.
// ----------------------------------------------------------------------------
module tmc_ctrl
  import tmc_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  output logic    busy,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  state_e     state_q, state_d;
  logic [3:0] cnt_q, cnt_d;
  logic [1:0] row_q, row_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      row_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      row_q   <= row_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    row_d   = row_q;
    cmd_o   = '0;
    cmd_o.iter   = cnt_q;
    cmd_o.rd_row = cnt_q[1:0];
    cmd_o.mac_k  = cnt_q[1:0];
    cmd_o.row    = row_q;
    busy    = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        busy = 1'b0;
        cnt_d = '0;
        row_d = '0;
        if (start) begin
          cmd_o.capture = 1'b1;
          if (sts_i.item_ok) begin
            state_d = sts_i.is_rot ? ST_CORDIC : ST_LOAD;
          end
        end
      end
      ST_CORDIC: begin
        cmd_o.cordic_step = 1'b1;
        if (cnt_q == 4'd15) begin
          cnt_d   = '0;
          state_d = ST_LOAD;
        end else begin
          cnt_d = cnt_q + 4'd1;
        end
      end
      ST_LOAD: begin
        cmd_o.rd_issue = ~cnt_q[2];
        if (cnt_q[2]) begin
          cnt_d   = '0;
          state_d = ST_MAC;
        end else begin
          cnt_d = cnt_q + 4'd1;
        end
      end
      ST_MAC: begin
        cmd_o.mac_issue = 1'b1;
        if (cnt_q[1:0] == 2'd3) begin
          cnt_d   = '0;
          state_d = ST_DRAIN;
        end else begin
          cnt_d = cnt_q + 4'd1;
        end
      end
      ST_DRAIN: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        cmd_o.finish = 1'b1;
        if (row_q == 2'd3) begin
          state_d = ST_IDLE;
        end else begin
          row_d   = row_q + 2'd1;
          state_d = ST_MAC;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/core/tmc_dpath.sv */
// ----------------------------------------------------------------------------
// tmc_dpath
// Datapath of the composer: CORDIC unit, elementary matrix entries,
// stored matrices, four-lane multiply-accumulate and output register.
// ----------------------------------------------------------------------------
module tmc_dpath
  import tmc_pkg::*;
#(
  parameter int NUM_OBJECTS = 16,
  parameter int FRAC_BITS   = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dp_cmd_t            cmd_i,
  output dp_sts_t            sts_o,
  input  logic [2:0]         opcode_i,
  input  logic [3:0]         object_index_i,
  input  logic [15:0]        angle_i,
  input  logic signed [15:0] shift_x_i,
  input  logic signed [15:0] shift_y_i,
  input  logic signed [15:0] shift_z_i,
  output logic               valid_o,
  output logic [1:0]         row_number_o,
  output logic signed [31:0] col0_o,
  output logic signed [31:0] col1_o,
  output logic signed [31:0] col2_o,
  output logic signed [31:0] col3_o,
  output logic               saturated_o,
  output logic               last_row_o
);

  localparam int OBJ_W = (NUM_OBJECTS > 1) ? $clog2(NUM_OBJECTS) : 1;
  localparam int DEPTH = NUM_OBJECTS * 4;
  localparam int AW    = $clog2(DEPTH);
  localparam int SH    = CordicFrac - FRAC_BITS;
  localparam logic signed [31:0] ONE  = 32'sd1 <<< FRAC_BITS;
  localparam logic signed [33:0] HALF = 34'sd1 <<< (SH - 1);
  localparam logic signed [65:0] RND  = 66'sd1 <<< (FRAC_BITS - 1);

  function automatic logic sts_rot(input logic [2:0] op);
    return (op == OP_ROT_X) || (op == OP_ROT_Y) || (op == OP_ROT_Z);
  endfunction

  logic [2:0]         op_q;
  logic [OBJ_W-1:0]   obj_q;
  logic               flip_q;
  logic signed [33:0] x_q, y_q, z_q;
  logic signed [31:0] s_q, c_q;
  logic signed [31:0] t_q   [3];
  logic               tsat_q [3];
  logic [NUM_OBJECTS-1:0] obj_valid_q;
  logic signed [31:0] buf_q [4][4];
  logic               rd_pend_q;
  logic [1:0]         rd_row_q;
  logic signed [63:0] p_q   [4];
  logic               pv_q, pfirst_q;
  logic signed [65:0] acc_q [4];
  logic               out_valid_q;
  logic [1:0]         out_row_q;
  logic signed [31:0] out_col_q [4];
  logic               out_sat_q;

  logic [15:0]        ang_off, ang_red;
  logic               flip_d;
  logic signed [33:0] xs, ys, xr, yr;
  logic signed [15:0] shift_in [3];
  logic signed [47:0] tw [3];
  logic               tsat_d [3];
  logic signed [31:0] tclip [3];
  logic [8:0]         obj_full;
  logic [AW-1:0]      addr_full;
  logic [31:0]        rdata [4];
  logic signed [31:0] e_val, s_neg;
  logic [1:0]         pp, qq;
  logic signed [65:0] ar [4];
  logic signed [31:0] res [4];
  logic [3:0]         col_sat;
  logic               ident_row;

  assign obj_full = {5'b0, object_index_i};
  assign sts_o.item_ok = (opcode_i <= OP_IDENT) && (obj_full < 9'(NUM_OBJECTS));
  assign sts_o.is_rot  = (opcode_i == OP_ROT_X) || (opcode_i == OP_ROT_Y) ||
                         (opcode_i == OP_ROT_Z);

  assign ang_off = angle_i + 16'd16384;
  assign flip_d  = ang_off[15];
  assign ang_red = flip_d ? (angle_i + 16'h8000) : angle_i;

  assign shift_in[0] = shift_x_i;
  assign shift_in[1] = shift_y_i;
  assign shift_in[2] = shift_z_i;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tw[i]     = {{32{shift_in[i][15]}}, shift_in[i]} <<< FRAC_BITS;
      tsat_d[i] = ~((&tw[i][47:31]) | ~(|tw[i][47:31]));
      if (tsat_d[i]) begin
        tclip[i] = tw[i][47] ? 32'sh80000000 : 32'sh7FFFFFFF;
      end else begin
        tclip[i] = tw[i][31:0];
      end
    end
  end

  assign xs = x_q >>> cmd_i.iter;
  assign ys = y_q >>> cmd_i.iter;
  assign xr = (x_q + HALF) >>> SH;
  assign yr = (y_q + HALF) >>> SH;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= opcode_i;
      obj_q  <= obj_full[OBJ_W-1:0];
      flip_q <= flip_d;
      x_q    <= CORDIC_X0;
      y_q    <= '0;
      z_q    <= {{2{ang_red[15]}}, ang_red, 16'b0};
      for (int i = 0; i < 3; i++) begin
        t_q[i]    <= tclip[i];
        tsat_q[i] <= tsat_d[i];
      end
    end else if (cmd_i.cordic_step) begin
      if (!z_q[33]) begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - $signed(34'(ATAN_TURNS[cmd_i.iter]));
      end else begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + $signed(34'(ATAN_TURNS[cmd_i.iter]));
      end
    end
    if (cmd_i.rd_issue) begin
      c_q <= flip_q ? -xr[31:0] : xr[31:0];
      s_q <= flip_q ? -yr[31:0] : yr[31:0];
    end
  end

  assign addr_full = AW'({obj_q, (cmd_i.finish ? cmd_i.row : cmd_i.rd_row)});

  for (genvar j = 0; j < 4; j++) begin : g_col
    tmc_ram #(
      .WIDTH(32),
      .DEPTH(DEPTH)
    ) u_ram (
      .clk_i  (clk_i),
      .we_i   (cmd_i.finish),
      .waddr_i(addr_full),
      .wdata_i(res[j]),
      .raddr_i(addr_full),
      .rdata_o(rdata[j])
    );
  end

  assign ident_row = (op_q == OP_IDENT) || !obj_valid_q[obj_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_pend_q   <= 1'b0;
      pv_q        <= 1'b0;
      out_valid_q <= 1'b0;
      obj_valid_q <= '0;
    end else begin
      rd_pend_q   <= cmd_i.rd_issue;
      pv_q        <= cmd_i.mac_issue;
      out_valid_q <= cmd_i.finish;
      if (cmd_i.finish && cmd_i.row == 2'd3) begin
        obj_valid_q[obj_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_row_q <= cmd_i.rd_row;
    if (rd_pend_q) begin
      for (int j = 0; j < 4; j++) begin
        buf_q[rd_row_q][j] <= ident_row ? ((rd_row_q == 2'(j)) ? ONE : '0)
                                        : $signed(rdata[j]);
      end
    end
  end

  always_comb begin
    pp = 2'd0;
    qq = 2'd1;
    unique case (op_q)
      OP_ROT_X: begin pp = 2'd1; qq = 2'd2; end
      OP_ROT_Y: begin pp = 2'd0; qq = 2'd2; end
      default:  begin pp = 2'd0; qq = 2'd1; end
    endcase
    s_neg = -s_q;
    e_val = (cmd_i.row == cmd_i.mac_k) ? ONE : '0;
    if (sts_rot(op_q)) begin
      if ((cmd_i.row == pp && cmd_i.mac_k == pp) ||
          (cmd_i.row == qq && cmd_i.mac_k == qq)) begin
        e_val = c_q;
      end else if (cmd_i.row == pp && cmd_i.mac_k == qq) begin
        e_val = (op_q == OP_ROT_Y) ? s_q : s_neg;
      end else if (cmd_i.row == qq && cmd_i.mac_k == pp) begin
        e_val = (op_q == OP_ROT_Y) ? s_neg : s_q;
      end
    end else if (op_q == OP_TRANS && cmd_i.mac_k == 2'd3 && cmd_i.row != 2'd3) begin
      e_val = t_q[cmd_i.row];
    end
  end

  always_ff @(posedge clk_i) begin
    pfirst_q <= (cmd_i.mac_k == 2'd0);
    for (int j = 0; j < 4; j++) begin
      if (cmd_i.mac_issue) begin
        p_q[j] <= e_val * buf_q[cmd_i.mac_k][j];
      end
      if (pv_q) begin
        acc_q[j] <= pfirst_q ? 66'(p_q[j]) : acc_q[j] + 66'(p_q[j]);
      end
    end
  end

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      ar[j] = (acc_q[j] + RND) >>> FRAC_BITS;
      col_sat[j] = ~((&ar[j][65:31]) | ~(|ar[j][65:31]));
      if (col_sat[j]) begin
        res[j] = ar[j][65] ? 32'sh80000000 : 32'sh7FFFFFFF;
      end else begin
        res[j] = ar[j][31:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_row_q <= cmd_i.row;
      for (int j = 0; j < 4; j++) begin
        out_col_q[j] <= res[j];
      end
      out_sat_q <= (|col_sat) ||
                   (op_q == OP_TRANS && cmd_i.row != 2'd3 && tsat_q[cmd_i.row]);
    end
  end

  assign valid_o      = out_valid_q;
  assign row_number_o = out_row_q;
  assign col0_o       = out_col_q[0];
  assign col1_o       = out_col_q[1];
  assign col2_o       = out_col_q[2];
  assign col3_o       = out_col_q[3];
  assign saturated_o  = out_sat_q;
  assign last_row_o   = (out_row_q == 2'd3);

endmodule

/* rtl/core/transform_matrix_composer_top.sv */
// ----------------------------------------------------------------------------
// transform_matrix_composer_top
// Keeps one 4x4 transform per object and premultiplies rotations,
// translations or identity reloads into it, emitting the four new rows.
//
//   channel   direction  handshake         payload
//   command   in         start / busy      opcode, object_index, angle, shift_*
//   row       out        valid_o strobe    row_number, col0..col3, saturated,
//                                          last_row
//
// Rotations first run the 16-step CORDIC; translations and identity reloads
// go straight to loading the stored matrix. Each row then takes four steps
// of the four-lane multiply-accumulate.
// Rejected transactions (bad opcode or object) leave the controller idle and emit nothing.
// After reset every object reads as identity; no clearing pass is needed.
// Rows are strobed for one cycle each; the receiver cannot stall.
// ----------------------------------------------------------------------------
module transform_matrix_composer_top
  import tmc_pkg::*;
#(
  parameter int NUM_OBJECTS = 16,
  parameter int FRAC_BITS   = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         opcode_i,
  input  logic [3:0]         object_index_i,
  input  logic [15:0]        angle_i,
  input  logic signed [15:0] shift_x_i,
  input  logic signed [15:0] shift_y_i,
  input  logic signed [15:0] shift_z_i,
  output logic               valid_o,
  output logic [1:0]         row_number_o,
  output logic signed [31:0] col0_o,
  output logic signed [31:0] col1_o,
  output logic signed [31:0] col2_o,
  output logic signed [31:0] col3_o,
  output logic               saturated_o,
  output logic               last_row_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  tmc_ctrl u_ctrl (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .sts_i (sts),
    .cmd_o (cmd)
  );

  tmc_dpath #(
    .NUM_OBJECTS(NUM_OBJECTS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .opcode_i      (opcode_i),
    .object_index_i(object_index_i),
    .angle_i       (angle_i),
    .shift_x_i     (shift_x_i),
    .shift_y_i     (shift_y_i),
    .shift_z_i     (shift_z_i),
    .valid_o       (valid_o),
    .row_number_o  (row_number_o),
    .col0_o        (col0_o),
    .col1_o        (col1_o),
    .col2_o        (col2_o),
    .col3_o        (col3_o),
    .saturated_o   (saturated_o),
    .last_row_o    (last_row_o)
  );

endmodule

/* dv/tmc_checker.sv */
// ----------------------------------------------------------------------------
// tmc_checker
// Watches the command and row channels of the transform matrix composer,
// predicts the four rows of each accepted transaction from a private copy
// of every object's matrix, and compares each strobed row field by field.
// ----------------------------------------------------------------------------
module tmc_checker
  import tmc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  logic               busy,
  input  logic [2:0]         opcode_i,
  input  logic [3:0]         object_index_i,
  input  logic [15:0]        angle_i,
  input  logic signed [15:0] shift_x_i,
  input  logic signed [15:0] shift_y_i,
  input  logic signed [15:0] shift_z_i,
  input  logic               valid_o,
  input  logic [1:0]         row_number_o,
  input  logic signed [31:0] col0_o,
  input  logic signed [31:0] col1_o,
  input  logic signed [31:0] col2_o,
  input  logic signed [31:0] col3_o,
  input  logic               saturated_o,
  input  logic               last_row_o,
  output int                 fail_count_o,
  output int                 pending_rows_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumObjects = 16;
  localparam int FracBits   = 16;
  localparam longint One    = 64'sd1 <<< FracBits;

  typedef struct packed {
    logic [1:0]         row_number;
    logic signed [31:0] col0;
    logic signed [31:0] col1;
    logic signed [31:0] col2;
    logic signed [31:0] col3;
    logic               saturated;
    logic               last_row;
  } row_t;

  logic signed [31:0] shadow_mtx [NumObjects][4][4];
  row_t               rows_due [$];
  int                 fail_count;

  assign fail_count_o   = fail_count;
  assign pending_rows_o = rows_due.size();

  function automatic logic signed [31:0] clamp32(longint v, ref logic flag);
    if (v > 64'sd2147483647) begin
      flag = 1'b1;
      return 32'sh7FFFFFFF;
    end
    if (v < -64'sd2147483648) begin
      flag = 1'b1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  task automatic calc_sin_cos(input logic [15:0] ang, output longint s, output longint c);
    logic [15:0] u;
    logic        flip;
    longint      x, y, z, nx;
    int          sh;
    u    = ang;
    flip = ((u + 16'd16384) >= 17'd32768) && ((u + 16'd16384) < 17'd65536)
           ? 1'b1 : 1'b0;
    flip = (16'(u + 16'd16384) >= 16'd32768);
    sh   = CordicFrac - FracBits;
    x    = longint'(CORDIC_X0);
    y    = 0;
    if (flip) u = u + 16'd32768;
    z = longint'($signed(u)) * 65536;
    for (int i = 0; i < CordicIters; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - longint'(ATAN_TURNS[i]);
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + longint'(ATAN_TURNS[i]);
      end
      x = nx;
    end
    x = (x + (64'sd1 <<< (sh - 1))) >>> sh;
    y = (y + (64'sd1 <<< (sh - 1))) >>> sh;
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  task automatic predict_rows(input logic [2:0] op, input logic [3:0] obj,
                              input logic [15:0] ang,
                              input logic signed [15:0] sx, input logic signed [15:0] sy,
                              input logic signed [15:0] sz);
    longint             elem [4][4];
    logic signed [31:0] res [4][4];
    logic               sat [4];
    longint             s, c, acc;
    int                 p, q;
    row_t               r_exp;
    logic signed [15:0] shifts [3];
    if (op > OP_IDENT || obj >= NumObjects) return;
    shifts = '{sx, sy, sz};
    for (int r = 0; r < 4; r++) begin
      sat[r] = 1'b0;
      for (int k = 0; k < 4; k++) begin
        elem[r][k] = (r == k) ? One : 0;
        res[r][k]  = (r == k) ? 32'(One) : 0;
      end
    end
    if (op != OP_IDENT) begin
      if (op == OP_TRANS) begin
        for (int r = 0; r < 3; r++)
          elem[r][3] = clamp32(longint'(shifts[r]) * One, sat[r]);
      end else begin
        p = (op == OP_ROT_X) ? 1 : 0;
        q = (op == OP_ROT_Z) ? 1 : 2;
        calc_sin_cos(ang, s, c);
        elem[p][p] = c;
        elem[q][q] = c;
        elem[p][q] = (op == OP_ROT_Y) ? s : -s;
        elem[q][p] = (op == OP_ROT_Y) ? -s : s;
      end
      for (int r = 0; r < 4; r++)
        for (int j = 0; j < 4; j++) begin
          acc = 0;
          for (int k = 0; k < 4; k++)
            acc = acc + elem[r][k] * longint'(shadow_mtx[obj][k][j]);
          acc = (acc + (One >>> 1)) >>> FracBits;
          res[r][j] = clamp32(acc, sat[r]);
        end
    end
    for (int r = 0; r < 4; r++) begin
      for (int j = 0; j < 4; j++) shadow_mtx[obj][r][j] = res[r][j];
      r_exp.row_number = 2'(r);
      r_exp.col0       = res[r][0];
      r_exp.col1       = res[r][1];
      r_exp.col2       = res[r][2];
      r_exp.col3       = res[r][3];
      r_exp.saturated  = sat[r];
      r_exp.last_row   = (r == 3);
      rows_due.push_back(r_exp);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    row_t r_exp;
    row_t r_got;
    if (!rst_ni) begin
      rows_due.delete();
      fail_count <= 0;
      for (int o = 0; o < NumObjects; o++)
        for (int r = 0; r < 4; r++)
          for (int k = 0; k < 4; k++)
            shadow_mtx[o][r][k] = (r == k) ? 32'(One) : 0;
    end else begin
      if (valid_o) begin
        r_got = '{row_number_o, col0_o, col1_o, col2_o, col3_o, saturated_o, last_row_o};
        if (rows_due.size() == 0) begin
          $display("%0t: unexpected row transaction %p", $time, r_got);
          fail_count <= fail_count + 1;
        end else begin
          r_exp = rows_due.pop_front();
          if (r_got !== r_exp) begin
            $display("%0t: row mismatch expected %p actual %p", $time, r_exp, r_got);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy)
        predict_rows(opcode_i, object_index_i, angle_i, shift_x_i, shift_y_i, shift_z_i);
    end
  end

endmodule

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Drives transform transactions into the matrix composer: a directed set of
// angle, translation and identity corner cases, then random transactions in
// phases of varying sender idling. The checker beside the block predicts and
// compares the emitted rows; the verdict is given here.
// ----------------------------------------------------------------------------
module tb;
  import tmc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 400000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [2:0]         opcode_i = OP_IDENT;
  logic [3:0]         object_index_i = '0;
  logic [15:0]        angle_i = '0;
  logic signed [15:0] shift_x_i = '0;
  logic signed [15:0] shift_y_i = '0;
  logic signed [15:0] shift_z_i = '0;
  logic               valid_o;
  logic [1:0]         row_number_o;
  logic signed [31:0] col0_o, col1_o, col2_o, col3_o;
  logic               saturated_o;
  logic               last_row_o;
  int                 fail_count;
  int                 pending_rows;
  int                 cycle_count = 0;
  int                 idle_pct = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  transform_matrix_composer_top u_top (.*);

  tmc_checker u_checker (
    .clk_i, .rst_ni, .start, .busy, .opcode_i, .object_index_i, .angle_i,
    .shift_x_i, .shift_y_i, .shift_z_i, .valid_o, .row_number_o, .col0_o,
    .col1_o, .col2_o, .col3_o, .saturated_o, .last_row_o,
    .fail_count_o(fail_count), .pending_rows_o(pending_rows)
  );

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_op(input logic [2:0] op, input logic [3:0] obj, input logic [15:0] ang,
                         input logic [15:0] sx, input logic [15:0] sy, input logic [15:0] sz);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct && gap < 40) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start          <= 1'b1;
    opcode_i       <= op;
    object_index_i <= obj;
    angle_i        <= ang;
    shift_x_i      <= sx;
    shift_y_i      <= sy;
    shift_z_i      <= sz;
    do @(negedge clk_i); while (busy);
    @(posedge clk_i);
  endtask

  task automatic send_random();
    int          sel;
    logic [2:0]  op;
    logic [15:0] sh [3];
    sel = $urandom_range(99);
    if (sel < 55)      op = 3'($urandom_range(2));
    else if (sel < 80) op = OP_TRANS;
    else if (sel < 93) op = OP_IDENT;
    else               op = 3'($urandom_range(7, 5));
    for (int i = 0; i < 3; i++)
      sh[i] = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($signed($urandom_range(64)) - 32);
    send_op(op, 4'($urandom_range(15)), 16'($urandom), sh[0], sh[1], sh[2]);
  endtask

  initial begin
    logic [15:0] angles [8];
    angles = '{16'd0, 16'd16383, 16'd16384, 16'd32768, 16'd49151, 16'd49152,
               16'd65535, 16'd8192};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_op(OP_IDENT, 4'd15, '0, '0, '0, '0);
    for (int i = 0; i < 8; i++)
      send_op(3'(i % 3), 4'd0, angles[i], '0, '0, '0);
    send_op(OP_TRANS, 4'd1, '0, 16'h7FFF, 16'h8000, 16'hFFFF);
    send_op(OP_TRANS, 4'd1, '0, 16'h7FFF, 16'h8000, 16'h0001);
    send_op(OP_TRANS, 4'd1, '0, 16'h7FFF, 16'h8000, 16'h5555);
    send_op(OP_ROT_Z, 4'd1, 16'hAAAA, '0, '0, '0);
    send_op(OP_TRANS, 4'd1, '0, 16'h7FFF, 16'h8000, 16'hAAAA);
    send_op(3'd5, 4'd2, '0, '0, '0, '0);
    send_op(3'd6, 4'd2, '0, '0, '0, '0);
    send_op(3'd7, 4'd2, '0, '0, '0, '0);
    send_op(OP_IDENT, 4'd1, '0, '0, '0, '0);
    send_op(OP_ROT_Y, 4'd15, 16'hFFFF, '0, '0, '0);
    start <= 1'b0;
    while (pending_rows != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1) ? 85 : (ph == 3) ? 30 : 0;
      repeat (120) send_random();
    end
    start <= 1'b0;

    while (pending_rows != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (fail_count == 0 && pending_rows == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
